[hdl/bounded_step_array_count_dp_macros.svh]
// Assertion macros used by the checker file of the array counting block.
`ifndef BOUNDED_STEP_ARRAY_COUNT_DP_MACROS_SVH
`define BOUNDED_STEP_ARRAY_COUNT_DP_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define BSAC_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define BSAC_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hdl/bsac_pkg.sv]
// Types and constants shared by the array counting block.
package bsac_pkg;

    localparam int unsigned COUNT_MOD       = 1000000007;
    localparam int unsigned COUNT_W         = 30;
    localparam logic [7:0]  MAX_VALUE_RESET = 8'd128;

    typedef logic [COUNT_W-1:0] t_count;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SWEEP,
        S_DONE
    } t_state;

    typedef struct packed {
        logic in_ready;
        logic init;
        logic sweep;
        logic rd_en;
        logic calc_en;
        logic load_out;
    } t_ctrl;

endpackage

[hdl/bounded_step_array_count_dp.sv]
// Counting of arrays whose neighbouring elements differ by at most one. Each
// input word carries one element (0 for a free value) and a flag that starts a
// new array; each produces one output word with the number of valid arrays for
// the prefix so far, modulo 1000000007. The row of MAX_VALUES counts lives in a
// single-port-write, registered-read memory and one modular adder walks it one
// entry per cycle; s_axis_tready stays low from acceptance until the result
// is loaded into the output register. A finished result waits in the output
// register while the next word is accepted. The row needs no clearing pass:
// every word rewrites all entries, and until the first word has finished,
// reads of the row are forced to zero.
module bounded_step_array_count_dp
    import bsac_pkg::*;
#(
    parameter int MAX_VALUES = 128
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [7:0]  i_cfg_wdata,     // max_value
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,    // [7:0] element
    input  logic [0:0]  s_axis_tuser,    // [0] first
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata     // [29:0] count, [31:30] zero
);

    localparam int IW = $clog2(MAX_VALUES);
    localparam int KW = $clog2(MAX_VALUES + 3);
    localparam int MW = (KW > 8) ? KW : 8;

    t_ctrl         w_ctrl;
    logic [KW-1:0] w_step;
    logic          w_start;
    logic          w_out_free;

    logic [7:0]    r_max_value;
    logic [7:0]    r_elem;
    logic          r_first;
    logic          r_row_valid;
    logic          r_rd_vld;
    t_count        r_win0;
    t_count        r_win1;
    t_count        r_ent;
    logic          r_ent_vld;
    t_count        r_total;
    logic          r_out_vld;
    t_count        r_out_data;

    logic [MW-1:0] w_max_ext;
    logic [MW-1:0] w_m;
    logic [MW-1:0] w_v;
    logic [MW-1:0] w_elem_ext;
    logic [IW-1:0] w_idx;
    logic          w_allow;
    t_count        w_mem_q;
    t_count        w_rd;
    t_count        w_up;
    t_count        w_sum;
    t_count        w_entry;
    t_count        w_acc;

    assign w_start    = s_axis_tvalid && w_ctrl.in_ready;
    assign w_out_free = !r_out_vld || m_axis_tready;

    bsac_ctrl #(
        .MAX_VALUES (MAX_VALUES),
        .KW         (KW)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_start),
        .i_out_free (w_out_free),
        .o_ctrl     (w_ctrl),
        .o_step     (w_step)
    );

    // Step k reads entry k and, two steps behind, works out entry k-2.
    assign w_idx      = IW'(w_step - KW'(2));
    assign w_v        = MW'(w_step - KW'(1));
    assign w_max_ext  = MW'(r_max_value);
    assign w_m        = (w_max_ext > MW'(MAX_VALUES)) ? MW'(MAX_VALUES) : w_max_ext;
    assign w_elem_ext = MW'(r_elem);
    assign w_allow    = (w_v <= w_m) && ((w_elem_ext == '0) || (w_elem_ext == w_v));

    bsac_row_mem #(
        .DEPTH (MAX_VALUES),
        .AW    (IW)
    ) u_row_mem (
        .i_clk   (i_clk),
        .i_we    (w_ctrl.calc_en),
        .i_waddr (w_idx),
        .i_wdata (w_entry),
        .i_re    (w_ctrl.rd_en),
        .i_raddr (w_step[IW-1:0]),
        .o_rdata (w_mem_q)
    );

    assign w_rd = (r_rd_vld && r_row_valid) ? w_mem_q : '0;
    // The upper neighbour only counts while it is still within the maximum.
    assign w_up = (w_v < w_m) ? w_rd : '0;

    bsac_modsum u_row_add (
        .i_a   (r_win0),
        .i_b   (r_win1),
        .i_c   (w_up),
        .o_sum (w_sum)
    );

    always_comb begin
        if (!w_allow) begin
            w_entry = '0;
        end else if (r_first) begin
            w_entry = COUNT_W'(1);
        end else begin
            w_entry = w_sum;
        end
    end

    bsac_modsum u_total_add (
        .i_a   (r_total),
        .i_b   (r_ent),
        .i_c   ('0),
        .o_sum (w_acc)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_value <= MAX_VALUE_RESET;
            r_row_valid <= 1'b0;
            r_rd_vld    <= 1'b0;
            r_ent_vld   <= 1'b0;
            r_out_vld   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_max_value <= i_cfg_wdata;
            end
            if (w_ctrl.load_out) begin
                r_row_valid <= 1'b1;
            end
            r_rd_vld  <= w_ctrl.rd_en;
            r_ent_vld <= w_ctrl.calc_en;
            if (w_ctrl.load_out) begin
                r_out_vld <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ctrl.init) begin
            r_elem  <= s_axis_tdata;
            r_first <= s_axis_tuser[0];
            r_win0  <= '0;
            r_win1  <= '0;
            r_total <= '0;
        end else begin
            if (w_ctrl.sweep) begin
                r_win0 <= r_win1;
                r_win1 <= w_rd;
            end
            if (r_ent_vld) begin
                r_total <= w_acc;
            end
        end
        r_ent <= w_entry;
        if (w_ctrl.load_out) begin
            r_out_data <= r_total;
        end
    end

    assign s_axis_tready = w_ctrl.in_ready;
    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = {2'b00, r_out_data};

endmodule

[hdl/bsac_modsum.sv]
// Modular adder: sum of three residues reduced modulo the count modulus.
module bsac_modsum
    import bsac_pkg::*;
(
    input  t_count i_a,
    input  t_count i_b,
    input  t_count i_c,
    output t_count o_sum
);

    logic [31:0] w_raw;

    assign w_raw = 32'(i_a) + 32'(i_b) + 32'(i_c);

    // Three residues sum to less than three times the modulus.
    always_comb begin
        if (w_raw >= 32'(2 * COUNT_MOD)) begin
            o_sum = COUNT_W'(w_raw - 32'(2 * COUNT_MOD));
        end else if (w_raw >= 32'(COUNT_MOD)) begin
            o_sum = COUNT_W'(w_raw - 32'(COUNT_MOD));
        end else begin
            o_sum = COUNT_W'(w_raw);
        end
    end

endmodule

[hdl/bsac_row_mem.sv]
// Row store: one write port and one registered read port.
module bsac_row_mem
    import bsac_pkg::*;
#(
    parameter int DEPTH = 128,
    parameter int AW    = 7
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  t_count        i_wdata,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr,
    output t_count        o_rdata
);

    t_count r_mem [DEPTH];
    t_count r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[hdl/bsac_ctrl.sv]
// Sequencer that steps the shared adder across the row once per input word.
module bsac_ctrl
    import bsac_pkg::*;
#(
    parameter int MAX_VALUES = 128,
    parameter int KW         = 8
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic          i_out_free,
    output t_ctrl         o_ctrl,
    output logic [KW-1:0] o_step
);

    localparam logic [KW-1:0] LAST_STEP = KW'(MAX_VALUES + 2);
    localparam logic [KW-1:0] CALC_END  = KW'(MAX_VALUES + 1);
    localparam logic [KW-1:0] READ_END  = KW'(MAX_VALUES);

    t_state        r_state;
    t_state        n_state;
    logic [KW-1:0] r_step;
    logic [KW-1:0] n_step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
        end
    end

    always_comb begin
        n_state = r_state;
        n_step  = r_step;
        unique case (r_state)
            S_IDLE: begin
                n_step = '0;
                if (i_start) begin
                    n_state = S_SWEEP;
                end
            end
            S_SWEEP: begin
                n_step = r_step + KW'(1);
                if (r_step == LAST_STEP) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (i_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        o_ctrl = '0;
        unique case (r_state)
            S_IDLE: begin
                o_ctrl.in_ready = 1'b1;
                o_ctrl.init     = i_start;
            end
            S_SWEEP: begin
                o_ctrl.sweep   = 1'b1;
                o_ctrl.rd_en   = (r_step < READ_END);
                // The window holds the entry and both neighbours from step two on.
                o_ctrl.calc_en = (r_step >= KW'(2)) && (r_step <= CALC_END);
            end
            S_DONE: begin
                o_ctrl.load_out = i_out_free;
            end
            default: begin
                o_ctrl = '0;
            end
        endcase
    end

    assign o_step = r_step;

endmodule

[hdl/bsac_checker.sv]
// Port-level checks for the array counting block, bound to its top level.
`include "bounded_step_array_count_dp_macros.svh"

module bsac_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [31:0] m_axis_tdata
);

    `BSAC_ASSERT_IMP(a_count_reduced, i_clk, i_rst_n, m_axis_tvalid, m_axis_tdata[29:0] < 30'd1000000007, "count word not reduced modulo the prime")
    `BSAC_ASSERT_IMP(a_pad_zero, i_clk, i_rst_n, m_axis_tvalid, m_axis_tdata[31:30] == 2'b00, "padding bits of the count word are set")
    `BSAC_ASSERT_NXT(a_busy_after_accept, i_clk, i_rst_n, s_axis_tvalid && s_axis_tready, !s_axis_tready, "input taken again while a word is being processed")
    `BSAC_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "stalled output word changed")

endmodule

bind bounded_step_array_count_dp bsac_checker u_bsac_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
